FILE: hdl/sch_pkg.sv
`timescale 1ns / 1ps

package sch_pkg;

  localparam int unsigned COUNT_W = 7;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  localparam logic [31:0] HASH_MIX     = 32'h0000_0061;
  localparam logic [31:0] HASH_MODULUS = 32'd107927;

  // Reciprocal of the modulus scaled by 2^40; the quotient it gives is at most one short.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [63:0] RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'd107927;
  localparam logic [23:0] HASH_RECIP  = RECIP_WIDE[23:0];

  localparam logic [2:0] REG_TEXT_MODE = 3'd0;

  typedef struct packed {
    logic [31:0]        lower;
    logic [31:0]        upper;
    logic [COUNT_W-1:0] count;
  } acc_t;

  typedef struct packed {
    logic [31:0]        lower;
    logic [31:0]        upper;
    logic [COUNT_W-1:0] length;
    logic               last;
  } chunk_rec_t;

  function automatic acc_t shift_in(acc_t a, logic [7:0] c);
    acc_t r;
    r.lower = ((a.lower << 7) ^ (a.upper >> 25)) + {24'b0, c};
    r.upper = (a.upper << 7) ^ (a.lower >> 25);
    r.count = a.count + 7'd1;
    return r;
  endfunction

endpackage

FILE: hdl/span_chunk_hasher.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     in_valid / in_ready         data_byte, end_of_buffer
// output    out_valid / out_ready       chunk_hash, chunk_length, last_of_run
// config    psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// One input transaction is taken per cycle while in_ready is high; a byte that
// closes a chunk becomes a result transaction through a four-entry chunk queue and
// a hash pipeline (mix multiply, reciprocal multiply, remainder, final correction).
// A byte that closes two chunks gives two results; in_ready falls while the
// queue holds more than two chunks. A stalled output holds the whole hash pipeline.
// Synchronous reset clears the chunk state and the queue and sets text_mode to 1.

module span_chunk_hasher #(
  parameter int MAX_CHUNK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] chunk_hash,
  output logic [6:0]  chunk_length,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [6:0] MaxCount = 7'(MAX_CHUNK_BYTES);

  sch_pkg::acc_t       acc, acc_cr, acc_mid, acc_byte, acc_end, acc_next;
  sch_pkg::chunk_rec_t rec_cr, rec_byte, rec_flush, rec0, rec1;
  sch_pkg::chunk_rec_t q_mem [4];
  logic                held_cr, text_mode;
  logic                cr_count, emit_cr, hold_new, emit_byte, flush;
  logic                in_accept, rec_pop, cfg_write;
  logic [1:0]          n_rec, n_push, wr_ptr, rd_ptr;
  logic [2:0]          used, used_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == sch_pkg::REG_TEXT_MODE) ? {31'b0, text_mode} : 32'b0;

  assign in_ready  = (used <= 3'd2);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    cr_count  = held_cr && !(text_mode && data_byte == sch_pkg::LF_BYTE);
    acc_cr    = sch_pkg::shift_in(acc, sch_pkg::CR_BYTE);
    emit_cr   = cr_count && (acc_cr.count >= MaxCount);
    acc_mid   = !cr_count ? acc : (emit_cr ? '0 : acc_cr);
    hold_new  = text_mode && data_byte == sch_pkg::CR_BYTE && !end_of_buffer;
    acc_byte  = sch_pkg::shift_in(acc_mid, data_byte);
    emit_byte = !hold_new && (acc_byte.count >= MaxCount || data_byte == sch_pkg::LF_BYTE);
    acc_end   = hold_new ? acc_mid : (emit_byte ? '0 : acc_byte);
    flush     = end_of_buffer && (acc_end.count != 7'd0);
    acc_next  = end_of_buffer ? '0 : acc_end;
    n_rec     = {1'b0, emit_cr} + {1'b0, emit_byte} + {1'b0, flush};

    rec_cr    = '{lower: acc_cr.lower, upper: acc_cr.upper, length: acc_cr.count,
                  last: 1'b0};
    rec_byte  = '{lower: acc_byte.lower, upper: acc_byte.upper, length: acc_byte.count,
                  last: 1'b0};
    rec_flush = '{lower: acc_end.lower, upper: acc_end.upper, length: acc_end.count,
                  last: 1'b0};

    rec0      = emit_cr ? rec_cr : (emit_byte ? rec_byte : rec_flush);
    rec1      = (emit_cr && emit_byte) ? rec_byte : rec_flush;
    rec0.last = (n_rec == 2'd1);
    rec1.last = 1'b1;

    n_push    = in_accept ? n_rec : 2'd0;
    used_next = used + {1'b0, n_push} - {2'b0, rec_pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      held_cr   <= 1'b0;
      text_mode <= 1'b1;
      wr_ptr    <= 2'd0;
      rd_ptr    <= 2'd0;
      used      <= 3'd0;
    end else begin
      if (in_accept) begin
        acc     <= acc_next;
        held_cr <= hold_new;
      end
      if (cfg_write && paddr == sch_pkg::REG_TEXT_MODE) begin
        text_mode <= pwdata[0];
      end
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, rec_pop};
      used   <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr] <= rec0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr + 2'd1] <= rec1;
    end
  end

  sch_hash u_hash (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (used != 3'd0),
    .rec          (q_mem[rd_ptr]),
    .rec_pop      (rec_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chunk_hash   (chunk_hash),
    .chunk_length (chunk_length),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: hdl/sch_hash.sv
`timescale 1ns / 1ps

module sch_hash (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  sch_pkg::chunk_rec_t  rec,
  output logic                 rec_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [16:0]          chunk_hash,
  output logic [6:0]           chunk_length,
  output logic                 last_of_run
);

  logic        adv;
  logic        v1, v2, v3;
  logic [31:0] mixed1, mixed2;
  logic [6:0]  len1, len2, len3;
  logic        last1, last2, last3;
  logic [15:0] q2;
  logic [17:0] r3;
  logic [55:0] prod1;
  logic [31:0] qd2;
  logic [17:0] modulus18;

  assign adv       = !out_valid || out_ready;
  assign rec_pop   = adv && rec_valid;
  assign prod1     = {24'b0, mixed1} * {32'b0, sch_pkg::HASH_RECIP};
  assign qd2       = {16'b0, q2} * sch_pkg::HASH_MODULUS;
  assign modulus18 = sch_pkg::HASH_MODULUS[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= rec_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mixed1       <= rec.lower + rec.upper * sch_pkg::HASH_MIX;
      len1         <= rec.length;
      last1        <= rec.last;
      mixed2       <= mixed1;
      q2           <= prod1[55:40];
      len2         <= len1;
      last2        <= last1;
      r3           <= 18'(mixed2 - qd2);
      len3         <= len2;
      last3        <= last2;
      chunk_hash   <= (r3 >= modulus18) ? 17'(r3 - modulus18) : r3[16:0];
      chunk_length <= len3;
      last_of_run  <= last3;
    end
  end

endmodule

FILE: hdl/sch_checker.sv
`timescale 1ns / 1ps

module sch_checker #(
  parameter int MAX_CHUNK_BYTES = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] chunk_hash,
  input logic [6:0]  chunk_length,
  input logic        last_of_run
);

  localparam logic [6:0] MaxCount = 7'(MAX_CHUNK_BYTES);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chunk_hash) &&
      $stable(chunk_length) && $stable(last_of_run))
    else $error("result transaction changed while stalled");

  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {15'b0, chunk_hash} < sch_pkg::HASH_MODULUS)
    else $error("chunk hash not reduced below the modulus");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chunk_length != 7'd0 && chunk_length <= MaxCount)
    else $error("chunk length out of range");

  // The second chunk of a pair follows directly behind the first.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second chunk of a pair did not follow");

endmodule

bind span_chunk_hasher sch_checker #(.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_sch_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .chunk_hash   (chunk_hash),
  .chunk_length (chunk_length),
  .last_of_run  (last_of_run)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int          CHUNK_LIMIT    = 64;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          TIMEOUT_NS     = 5_000_000;
  localparam logic [2:0]  ADDR_TEXT_MODE = 3'(4 * sch_pkg::REG_TEXT_MODE);
  localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
  localparam logic [7:0]  LETTER_A       = 8'h61;
  localparam logic [7:0]  LETTER_Q       = 8'h71;
  localparam logic [7:0]  LETTER_X       = 8'h78;

  typedef struct packed {
    logic [7:0] value;
    logic       eob;
  } byte_item_t;

  typedef struct packed {
    logic [16:0] hash;
    logic [6:0]  len;
    logic        last;
  } chunk_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte     = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [16:0] chunk_hash;
  logic [6:0]  chunk_length;
  logic        last_of_run;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  span_chunk_hasher dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  byte_item_t  pending_bytes[$];
  chunk_t      expected_chunks[$];
  byte_item_t  current_byte;
  chunk_t      oldest_chunk;

  logic [31:0] hash_lower    = 32'h0;
  logic [31:0] hash_upper    = 32'h0;
  logic [6:0]  chunk_fill    = 7'd0;
  logic        cr_pending    = 1'b0;
  logic        text_mode_now = 1'b1;
  int          chunks_this_byte;

  logic        in_flight   = 1'b0;
  logic        send_steady = 1'b0;
  logic        take_steady = 1'b0;
  int          send_gap    = 0;
  int          take_gap    = 0;

  int          mismatches    = 0;
  int          bytes_taken   = 0;
  int          chunks_seen   = 0;
  int          mode_writes   = 0;
  int          two_chunk_bytes = 0;

  function automatic void close_chunk();
    logic [31:0] mixed;
    chunk_t      c;
    mixed    = hash_lower + hash_upper * sch_pkg::HASH_MIX;
    c.hash   = 17'(mixed % sch_pkg::HASH_MODULUS);
    c.len    = chunk_fill;
    c.last   = 1'b0;
    expected_chunks.push_back(c);
    chunks_this_byte++;
    hash_lower = 32'h0;
    hash_upper = 32'h0;
    chunk_fill = 7'd0;
  endfunction

  function automatic void shift_byte(logic [7:0] b);
    logic [31:0] old_lower;
    old_lower  = hash_lower;
    hash_lower = ((hash_lower << 7) ^ (hash_upper >> 25)) + {24'b0, b};
    hash_upper = (hash_upper << 7) ^ (old_lower >> 25);
    chunk_fill = chunk_fill + 7'd1;
    if (chunk_fill >= 7'(CHUNK_LIMIT) || b == sch_pkg::LF_BYTE) close_chunk();
  endfunction

  // In text mode a CR is held back until the next byte shows whether it starts a CR LF pair.
  function automatic void predict_byte(byte_item_t item);
    chunk_t c;
    chunks_this_byte = 0;
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (!(text_mode_now && item.value == sch_pkg::LF_BYTE)) shift_byte(sch_pkg::CR_BYTE);
    end
    if (text_mode_now && item.value == sch_pkg::CR_BYTE && !item.eob) begin
      cr_pending = 1'b1;
    end else begin
      shift_byte(item.value);
    end
    if (item.eob) begin
      if (chunk_fill != 7'd0) close_chunk();
      cr_pending = 1'b0;
    end
    if (chunks_this_byte > 0) begin
      c = expected_chunks.pop_back();
      c.last = 1'b1;
      expected_chunks.push_back(c);
    end
    if (chunks_this_byte > 1) two_chunk_bytes++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_flight = 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(current_byte);
        bytes_taken++;
        in_flight = 1'b0;
        send_gap  = send_steady ? 0 : $urandom_range(0, 7);
      end
      if (!in_flight) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0) begin
          current_byte = pending_bytes.pop_front();
          data_byte     <= current_byte.value;
          end_of_buffer <= current_byte.eob;
          in_flight = 1'b1;
        end
      end
      in_valid <= in_flight;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        chunks_seen++;
        if (expected_chunks.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected chunk transaction hash %0d length %0d last %0b",
                     $time, chunk_hash, chunk_length, last_of_run);
          mismatches++;
        end else begin
          oldest_chunk = expected_chunks.pop_front();
          if (chunk_hash !== oldest_chunk.hash || chunk_length !== oldest_chunk.len ||
              last_of_run !== oldest_chunk.last) begin
            if (mismatches < 10)
              $display({"%0t: chunk mismatch, expected hash %0d length %0d last %0b,",
                        " got %0d %0d %0b"},
                       $time, oldest_chunk.hash, oldest_chunk.len, oldest_chunk.last,
                       chunk_hash, chunk_length, last_of_run);
            mismatches++;
          end
        end
        take_gap = take_steady ? 0 : $urandom_range(0, 7);
      end
      if (take_gap != 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void push_byte(logic [7:0] value, logic eob);
    byte_item_t item;
    item.value = value;
    item.eob   = eob;
    pending_bytes.push_back(item);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == sch_pkg::CR_BYTE || b == sch_pkg::LF_BYTE);
    return b;
  endfunction

  // Buffers range from short lines to long runs with no newline, plus runs that put a
  // carriage return right at the chunk boundary.
  function automatic int queue_buffer(logic close);
    logic [7:0] bytes_q[$];
    int         kind;
    int         len;
    int         lf_odds;
    int         cr_odds;
    int         pick;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(62, 64);
      repeat (len) bytes_q.push_back(plain_byte());
      bytes_q.push_back(sch_pkg::CR_BYTE);
      case ($urandom_range(0, 2))
        0: bytes_q.push_back(sch_pkg::LF_BYTE);
        1: bytes_q.push_back(sch_pkg::CR_BYTE);
        default: bytes_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end else begin
      len     = $urandom_range(1, kind < 4 ? 6 : 140);
      lf_odds = $urandom_range(0, 4);
      cr_odds = $urandom_range(0, 4);
      repeat (len) begin
        pick = $urandom_range(0, 31);
        if (pick < lf_odds) begin
          bytes_q.push_back(sch_pkg::LF_BYTE);
        end else if (pick < lf_odds + cr_odds) begin
          bytes_q.push_back(sch_pkg::CR_BYTE);
        end else if (pick == 31) begin
          bytes_q.push_back(sch_pkg::CR_BYTE);
          bytes_q.push_back(sch_pkg::LF_BYTE);
        end else begin
          bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i], close && i == bytes_q.size() - 1);
    return bytes_q.size();
  endfunction

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_flight || expected_chunks.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] value, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_mode();
    logic [31:0] rdata;
    apb_access(1'b0, ADDR_TEXT_MODE, 32'h0, rdata);
    if (rdata !== {31'b0, text_mode_now}) begin
      if (mismatches < 10)
        $display("%0t: text_mode read mismatch, expected %0d, got %0h",
                 $time, text_mode_now, rdata);
      mismatches++;
    end
  endtask

  task automatic write_mode(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rdata;
    wait_idle();
    apb_access(1'b1, addr, value, rdata);
    if (addr == ADDR_TEXT_MODE) text_mode_now = value[0];
    mode_writes++;
    check_mode();
  endtask

  initial begin
    logic [31:0] word;
    int          phase_bytes;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    check_mode();

    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(LETTER_A, 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(sch_pkg::LF_BYTE, 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(LETTER_X, 1'b0);
    push_byte(sch_pkg::LF_BYTE, 1'b0);
    push_byte(sch_pkg::LF_BYTE, 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(sch_pkg::LF_BYTE, 1'b1);
    write_mode(ADDR_UNUSED, 32'h0);

    repeat (63) push_byte(plain_byte(), 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(LETTER_Q, 1'b1);
    repeat (63) push_byte(plain_byte(), 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b0);
    write_mode(ADDR_TEXT_MODE, 32'h0);
    push_byte(sch_pkg::LF_BYTE, 1'b1);

    push_byte(sch_pkg::CR_BYTE, 1'b0);
    push_byte(sch_pkg::LF_BYTE, 1'b0);
    push_byte(sch_pkg::CR_BYTE, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    write_mode(ADDR_TEXT_MODE, 32'hFFFF_FFFE);

    for (int phase = 0; phase < 6; phase++) begin
      word    = (phase == 0) ? 32'hFFFF_FFFF : $urandom;
      word[0] = ~phase[0];
      write_mode(ADDR_TEXT_MODE, word);
      send_steady = ($urandom_range(0, 3) == 0);
      take_steady = ($urandom_range(0, 3) == 0);
      phase_bytes = 0;
      while (phase_bytes < 80) phase_bytes += queue_buffer(1'b1);
      if ($urandom_range(0, 1) == 1) phase_bytes += queue_buffer(1'b0);
    end

    wait_idle();
    $display("tb_top: %0d bytes taken, %0d chunk transactions compared, %0d with two chunks",
             bytes_taken, chunks_seen, two_chunk_bytes);
    $display("tb_top: %0d register writes, text mode on and off, %0d mismatches",
             mode_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sch_pkg.sv
hdl/sch_hash.sv
hdl/span_chunk_hasher.sv
hdl/sch_checker.sv
bench/tb_top.sv
